// ----- src/nmea_rmc_pkg.sv -----
// shared types and constants for the rmc time extractor
// no dependencies; imported by nmea_rmc_parse and nmea_rmc_time_extractor
`timescale 1ns / 1ps

package nmea_rmc_pkg;

   localparam int CHAR_W    = 8;
   localparam int DIGIT_W   = 4;
   localparam int NUM_DIGITS = 6;
   localparam int OFFSET_W  = 5;
   localparam int HOUR_W    = 5;
   localparam int MINSEC_W  = 7;
   localparam int RSP_W     = 24;   // 21 payload bits padded to whole bytes

   localparam logic [OFFSET_W-1:0] OFFSET_RESET = 5'd8;

   // per-sentence verdict handed from the parser to the output stage
   typedef struct packed {
      logic                                ok;
      logic [NUM_DIGITS-1:0][DIGIT_W-1:0]  digits;
   } verdict_type;

endpackage

// ----- src/nmea_rmc_parse.sv -----
// sentence tracker: header match, status field, time digits and checksum
// depends on nmea_rmc_pkg
`timescale 1ns / 1ps

module nmea_rmc_parse (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  logic [7:0]                     char_in,
   input  logic                           is_last,
   output nmea_rmc_pkg::verdict_type      verdict
);
   import nmea_rmc_pkg::*;

   localparam logic [CHAR_W-1:0] HEADER [NUM_DIGITS] = '{8'h24, 8'h47, 8'h50, 8'h52, 8'h4D, 8'h43};
   localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'h2C;
   localparam logic [CHAR_W-1:0] CHAR_STAR  = 8'h2A;
   localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_F     = 8'h46;
   localparam logic [1:0]        COMMA_DONE = 2'd3;
   localparam logic [1:0]        HEX_BAD    = 2'd3;
   localparam logic [1:0]        HEX_FULL   = 2'd2;

   logic [7:0]                           pos_ff, pos_in;
   logic [1:0]                           comma_ff, comma_in;
   logic                                 hdr_ok_ff, hdr_ok_in;
   logic                                 status_ok_ff, status_ok_in;
   logic                                 digits_ok_ff, digits_ok_in;
   logic [7:0]                           xor_ff, xor_in;
   logic                                 in_ck_ff, in_ck_in;
   logic [1:0]                           hex_cnt_ff, hex_cnt_in;
   logic [7:0]                           rsum_ff, rsum_in;
   logic [NUM_DIGITS-1:0][DIGIT_W-1:0]   dig_ff, dig_in;

   logic                                 is_digit;
   logic                                 is_hex;
   logic [3:0]                           hex_val;
   logic [2:0]                           dig_idx;

   always_comb begin
      is_digit = (char_in >= CHAR_0) && (char_in <= CHAR_9);
      is_hex   = is_digit || ((char_in >= CHAR_A) && (char_in <= CHAR_F));
      // 'A'..'F' low nibble is 1..6, value is that plus 9
      hex_val  = is_digit ? char_in[3:0] : 4'(char_in[3:0] + 4'd9);
      dig_idx  = 3'(pos_ff - 8'd7);

      pos_in       = (pos_ff == 8'hFF) ? pos_ff : 8'(pos_ff + 8'd1);
      comma_in     = comma_ff;
      hdr_ok_in    = hdr_ok_ff;
      status_ok_in = status_ok_ff;
      digits_ok_in = digits_ok_ff;
      xor_in       = xor_ff;
      in_ck_in     = in_ck_ff;
      hex_cnt_in   = hex_cnt_ff;
      rsum_in      = rsum_ff;
      dig_in       = dig_ff;

      if (pos_ff < 8'd6 && char_in != HEADER[pos_ff[2:0]]) begin
         hdr_ok_in = 1'b0;
      end

      // hhmmss sits at byte positions 7 through 12
      if (pos_ff >= 8'd7 && pos_ff <= 8'd12) begin
         if (is_digit) begin
            dig_in[dig_idx] = char_in[3:0];
         end else begin
            digits_ok_in = 1'b0;
         end
      end

      priority if (in_ck_ff) begin
         if (is_hex && hex_cnt_ff < HEX_FULL) begin
            rsum_in    = {rsum_ff[3:0], hex_val};
            hex_cnt_in = 2'(hex_cnt_ff + 2'd1);
         end else begin
            hex_cnt_in = HEX_BAD;
         end
      end else if (pos_ff != 8'd0) begin
         if (char_in == CHAR_STAR) begin
            in_ck_in = 1'b1;
         end else begin
            xor_in = xor_ff ^ char_in;
            priority if (comma_ff == 2'd2) begin
               status_ok_in = (char_in == CHAR_A);
               comma_in     = COMMA_DONE;
            end else if (comma_ff < 2'd2 && char_in == CHAR_COMMA) begin
               comma_in = 2'(comma_ff + 2'd1);
            end else begin
               comma_in = comma_ff;
            end
         end
      end else begin
         in_ck_in = in_ck_ff;
      end

      verdict.ok = hdr_ok_in && (pos_in >= 8'd13) && digits_ok_in && status_ok_in
                   && in_ck_in && (hex_cnt_in == HEX_FULL) && (rsum_in == xor_in);
      verdict.digits = dig_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (step && is_last)) begin
         pos_ff       <= '0;
         comma_ff     <= '0;
         hdr_ok_ff    <= 1'b1;
         status_ok_ff <= 1'b0;
         digits_ok_ff <= 1'b1;
         xor_ff       <= '0;
         in_ck_ff     <= 1'b0;
         hex_cnt_ff   <= '0;
         rsum_ff      <= '0;
         dig_ff       <= '0;
      end else if (step) begin
         pos_ff       <= pos_in;
         comma_ff     <= comma_in;
         hdr_ok_ff    <= hdr_ok_in;
         status_ok_ff <= status_ok_in;
         digits_ok_ff <= digits_ok_in;
         xor_ff       <= xor_in;
         in_ck_ff     <= in_ck_in;
         hex_cnt_ff   <= hex_cnt_in;
         rsum_ff      <= rsum_in;
         dig_ff       <= dig_in;
      end
   end

endmodule

// ----- src/nmea_rmc_time_extractor.sv -----
// rmc time extractor: one sentence byte per word in, one verdict word per sentence out
// the verdict word is registered in the output stage as the last byte of its sentence leaves the input register
// throughput: one byte per cycle while no byte stalls, set by the single input register feeding the parser
// a byte stalls in the input register only while an earlier verdict waits on rsp_tready
// reset (synchronous, active high) clears both stages, held time and sets the offset to 8
// depends on nmea_rmc_pkg and nmea_rmc_parse
`timescale 1ns / 1ps

module nmea_rmc_time_extractor (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [nmea_rmc_pkg::CHAR_W-1:0]        req_tdata,   // char_in
   input  logic                                   req_tlast,   // is_last
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // accepted, time_valid, hour[4:0], minute[6:0], second[6:0], zero pad
   output logic [nmea_rmc_pkg::RSP_W-1:0]         rsp_tdata,
   input  logic                                   csr_we,
   input  logic [nmea_rmc_pkg::OFFSET_W-1:0]      csr_wdata    // zone_offset_hours
);
   import nmea_rmc_pkg::*;

   logic                   s1_valid_ff;
   logic [CHAR_W-1:0]      s1_char_ff;
   logic                   s1_last_ff;
   logic                   s1_adv;
   logic                   out_free;

   logic [OFFSET_W-1:0]    offset_ff;
   logic                   have_time_ff;
   logic [HOUR_W-1:0]      hour_ff, hour_in;
   logic [MINSEC_W-1:0]    minute_ff, minute_in;
   logic [MINSEC_W-1:0]    second_ff, second_in;

   logic                   rsp_valid_ff;
   logic [RSP_W-1:0]       rsp_data_ff, rsp_data_in;

   verdict_type            verdict;
   logic [7:0]             hour_sum;
   logic [15:0]            quot_prod;
   logic [2:0]             quot;
   logic                   finish;

   nmea_rmc_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .step    (s1_adv),
      .char_in (s1_char_ff),
      .is_last (s1_last_ff),
      .verdict (verdict)
   );

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_adv     = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign finish     = s1_adv && s1_last_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      // received hour plus offset, at most 130 with decimal digits
      hour_sum = 8'({verdict.digits[0], 3'b000}) + 8'({verdict.digits[0], 1'b0})
                 + 8'(verdict.digits[1]) + 8'(offset_ff);
      // divide by 24 via 171/4096, exact for values up to 130
      quot_prod = 16'(hour_sum) * 16'd171;
      quot      = quot_prod[14:12];
      hour_in   = 5'(hour_sum - 8'({quot, 4'b0000}) - 8'({quot, 3'b000}));
      minute_in = 7'({verdict.digits[2], 3'b000}) + 7'({verdict.digits[2], 1'b0})
                  + 7'(verdict.digits[3]);
      second_in = 7'({verdict.digits[4], 3'b000}) + 7'({verdict.digits[4], 1'b0})
                  + 7'(verdict.digits[5]);

      rsp_data_in = '0;
      rsp_data_in[0] = verdict.ok;
      if (verdict.ok) begin
         rsp_data_in[1]    = 1'b1;
         rsp_data_in[6:2]  = hour_in;
         rsp_data_in[13:7] = minute_in;
         rsp_data_in[20:14] = second_in;
      end else begin
         rsp_data_in[1]    = have_time_ff;
         rsp_data_in[6:2]  = hour_ff;
         rsp_data_in[13:7] = minute_ff;
         rsp_data_in[20:14] = second_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_char_ff <= req_tdata;
         s1_last_ff <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= OFFSET_RESET;
      end else if (csr_we) begin
         offset_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_time_ff <= 1'b0;
         hour_ff      <= '0;
         minute_ff    <= '0;
         second_ff    <= '0;
      end else if (finish && verdict.ok) begin
         have_time_ff <= 1'b1;
         hour_ff      <= hour_in;
         minute_ff    <= minute_in;
         second_ff    <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

`ifndef ASSERT_OFF
   a_accept_sets_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[1])
      else $error("accepted word without time_valid");

   a_hour_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[6:2] < 5'd24)
      else $error("hour out of range");

   a_time_sticky: assert property (@(posedge clock) disable iff (reset)
      have_time_ff |=> have_time_ff)
      else $error("held time lost");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff && $stable(s1_char_ff) && $stable(s1_last_ff))
      else $error("input stage overwritten");

   a_no_verdict_overrun: assert property (@(posedge clock) disable iff (reset)
      finish |-> out_free)
      else $error("verdict issued into a full output register");
`endif

endmodule

// ----- tb/sv/nmea_rmc_time_extractor_tb.sv -----
// testbench for nmea_rmc_time_extractor: byte-wise rmc sentences in, one verdict word each
// a scoreboard class predicts each verdict and held time; depends on nmea_rmc_pkg and the dut rtl
`timescale 1ns / 1ps

package nmea_rmc_tb_pkg;
   import nmea_rmc_pkg::*;

   typedef bit [7:0] octet_type;

   localparam octet_type CH_DOLLAR      = 8'h24;
   localparam octet_type CH_COMMA       = 8'h2C;
   localparam octet_type CH_STAR        = 8'h2A;
   localparam octet_type CH_ZERO        = 8'h30;
   localparam octet_type CH_NINE        = 8'h39;
   localparam octet_type CH_UPPER_A     = 8'h41;
   localparam octet_type CH_UPPER_F     = 8'h46;
   localparam octet_type CH_STATUS_OK   = 8'h41;   // 'A'
   localparam octet_type CH_STATUS_VOID = 8'h56;   // 'V'
   localparam logic [47:0] RMC_HEADER = "$GPRMC";
   localparam int HEADER_LEN    = 6;
   localparam int TIME_FIRST    = 7;
   localparam int TIME_LAST     = 12;
   localparam int MIN_LEN       = 13;
   localparam int POS_MAX       = 255;
   localparam int HOURS_PER_DAY = 24;

   // ways the checksum tail of a sentence is written
   typedef enum int {
      SUM_GOOD, SUM_BAD, SUM_LOWER, SUM_SHORT, SUM_LONG, SUM_STAR, SUM_NONE
   } sum_kind_type;

   // result word, lowest bit last
   typedef struct packed {
      logic [2:0]          pad;
      logic [MINSEC_W-1:0] second;
      logic [MINSEC_W-1:0] minute;
      logic [HOUR_W-1:0]   hour;
      logic                time_valid;
      logic                accepted;
   } rmc_word_type;

   class rmc_scoreboard;
      logic [OFFSET_W-1:0] zone_offset;
      bit [7:0]            position;
      bit [1:0]            commas;
      bit                  header_good;
      bit                  status_good;
      bit                  digits_good;
      bit [7:0]            running_xor;
      bit                  in_sum;
      bit [1:0]            hex_seen;
      bit [7:0]            sum_field;
      bit [DIGIT_W-1:0]    time_digits [NUM_DIGITS];
      bit [HOUR_W-1:0]     held_hour;
      bit [MINSEC_W-1:0]   held_minute;
      bit [MINSEC_W-1:0]   held_second;
      bit                  have_time;
      rmc_word_type        expected_q[$];
      int                  mismatches;

      function new();
         zone_offset = OFFSET_RESET;
         held_hour   = '0;
         held_minute = '0;
         held_second = '0;
         have_time   = 1'b0;
         mismatches  = 0;
         clear_sentence();
      endfunction

      function void clear_sentence();
         position    = '0;
         commas      = '0;
         header_good = 1'b1;
         status_good = 1'b0;
         digits_good = 1'b1;
         running_xor = '0;
         in_sum      = 1'b0;
         hex_seen    = '0;
         sum_field   = '0;
         foreach (time_digits[i]) time_digits[i] = '0;
      endfunction

      function octet_type header_char(int i);
         return RMC_HEADER[8*(HEADER_LEN-1-i) +: 8];
      endfunction

      function int hex_value(octet_type c);
         if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
         if (c >= CH_UPPER_A && c <= CH_UPPER_F) return int'(c - CH_UPPER_A) + 10;
         return -1;
      endfunction

      // one accepted input word; queues a verdict when it closes a sentence
      function void note_byte(octet_type c, bit last);
         int           v;
         int           hours;
         bit           ok;
         rmc_word_type w;
         if (position < HEADER_LEN && c != header_char(position)) header_good = 1'b0;
         if (position >= TIME_FIRST && position <= TIME_LAST) begin
            if (c >= CH_ZERO && c <= CH_NINE)
               time_digits[position-TIME_FIRST] = DIGIT_W'(c - CH_ZERO);
            else digits_good = 1'b0;
         end
         if (in_sum) begin
            v = hex_value(c);
            if (v >= 0 && hex_seen < 2) begin
               sum_field = {sum_field[3:0], v[3:0]};
               hex_seen++;
            end else begin
               hex_seen = 2'd3;
            end
         end else if (position > 0) begin
            if (c == CH_STAR) begin
               in_sum = 1'b1;
            end else begin
               running_xor ^= c;
               // the byte right after the second comma is the status
               if (commas == 2) begin
                  status_good = (c == CH_STATUS_OK);
                  commas = 2'd3;
               end else if (commas < 2 && c == CH_COMMA) begin
                  commas++;
               end
            end
         end
         if (position < POS_MAX) position++;
         if (!last) return;

         ok = header_good && position >= MIN_LEN && digits_good && status_good
              && in_sum && hex_seen == 2 && sum_field == running_xor;
         if (ok) begin
            hours       = time_digits[0] * 10 + time_digits[1] + zone_offset;
            held_hour   = HOUR_W'(hours % HOURS_PER_DAY);
            held_minute = MINSEC_W'(time_digits[2] * 10 + time_digits[3]);
            held_second = MINSEC_W'(time_digits[4] * 10 + time_digits[5]);
            have_time   = 1'b1;
         end
         w            = '0;
         w.accepted   = ok;
         w.time_valid = have_time;
         w.hour       = held_hour;
         w.minute     = held_minute;
         w.second     = held_second;
         expected_q.push_back(w);
         clear_sentence();
      endfunction

      function void report(string what, rmc_word_type want, rmc_word_type got);
         mismatches++;
         if (mismatches <= 10)
            $display({"%0s: expected acc=%0d valid=%0d %0d:%0d:%0d, ",
                      "got acc=%0d valid=%0d %0d:%0d:%0d"},
                     what, want.accepted, want.time_valid, want.hour, want.minute,
                     want.second, got.accepted, got.time_valid, got.hour, got.minute,
                     got.second);
      endfunction

      function void check_word(logic [RSP_W-1:0] data);
         rmc_word_type got;
         rmc_word_type want;
         got = data;
         if (expected_q.size() == 0) begin
            report("verdict with nothing pending", '0, got);
         end else begin
            want = expected_q.pop_front();
            if (got.accepted !== want.accepted || got.time_valid !== want.time_valid
                || got.hour !== want.hour || got.minute !== want.minute
                || got.second !== want.second)
               report("verdict mismatch", want, got);
         end
      endfunction
   endclass

endpackage

module nmea_rmc_time_extractor_tb;
   import nmea_rmc_pkg::*;
   import nmea_rmc_tb_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 6;
   localparam int PHASE_BYTES   = 12;
   localparam int PHASE_VERDICTS = 1;
   localparam int NUM_PHASES    = 6;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic [CHAR_W-1:0]   req_tdata  = '0;
   logic                req_tlast  = 1'b0;
   logic                rsp_tready = 1'b0;
   logic                csr_we     = 1'b0;
   logic [OFFSET_W-1:0] csr_wdata  = '0;
   logic                req_tready;
   logic                rsp_tvalid;
   logic [RSP_W-1:0]    rsp_tdata;

   rmc_scoreboard sb = new();

   octet_type   sentence[$];
   int          burst_left = 0;
   bit          tx_gaps    = 1'b1;
   bit          rx_stalls  = 1'b1;
   int unsigned rx_cycle   = 0;

   nmea_rmc_time_extractor dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // receiver: a long periodic stall plus random single-cycle stalls, always ready when rx_stalls is 0
   always @(posedge clock) begin
      rx_cycle <= rx_cycle + 1;
      if (!rx_stalls) rsp_tready <= 1'b1;
      else rsp_tready <= (rx_cycle[5:0] < 6'd52) && ($urandom_range(0, 3) != 0);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_word(rsp_tdata);
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("[nmea_rmc_time_extractor] ERROR");
      $finish;
   end

   task automatic send_byte(octet_type c, bit last);
      int gap;
      if (burst_left == 0) begin
         gap = tx_gaps ? $urandom_range(1, 6) : 0;
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_byte(c, last);
      burst_left--;
   endtask

   task automatic send_sentence();
      foreach (sentence[i]) send_byte(sentence[i], i == sentence.size() - 1);
   endtask

   // hold the sender until every verdict is back, optionally letting the pipe empty
   task automatic drain(bit settle);
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (sb.expected_q.size() != 0) @(posedge clock);
      if (settle) repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_offset(logic [OFFSET_W-1:0] value);
      drain(1'b1);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.zone_offset = value;
   endtask

   function automatic octet_type hex_char(bit [3:0] v);
      return (v < 4'd10) ? octet_type'(CH_ZERO + v) : octet_type'(CH_UPPER_A + v - 8'd10);
   endfunction

   task automatic push_two_digits(int n);
      sentence.push_back(octet_type'(CH_ZERO + n / 10));
      sentence.push_back(octet_type'(CH_ZERO + n % 10));
   endtask

   task automatic begin_rmc(int hh, int mm, int ss, octet_type status);
      sentence.delete();
      for (int i = 0; i < HEADER_LEN; i++) sentence.push_back(sb.header_char(i));
      sentence.push_back(CH_COMMA);
      push_two_digits(hh);
      push_two_digits(mm);
      push_two_digits(ss);
      sentence.push_back(CH_COMMA);
      sentence.push_back(status);
   endtask

   // random field content, every byte value except the star
   task automatic add_field(int len);
      octet_type c;
      sentence.push_back(CH_COMMA);
      repeat (len) begin
         c = octet_type'($urandom_range(0, 255));
         if (c == CH_STAR) c = CH_COMMA;
         sentence.push_back(c);
      end
   endtask

   task automatic close_sum(sum_kind_type kind);
      octet_type x;
      octet_type hi;
      octet_type lo;
      x = '0;
      for (int i = 1; i < sentence.size(); i++) x ^= sentence[i];
      if (kind == SUM_BAD) x ^= 8'(1 << $urandom_range(0, 7));
      if (kind == SUM_NONE) return;
      sentence.push_back(CH_STAR);
      hi = hex_char(x[7:4]);
      lo = hex_char(x[3:0]);
      case (kind)
         SUM_LOWER: begin
            sentence.push_back(hi | 8'h20);
            sentence.push_back(lo | 8'h20);
         end
         SUM_SHORT: sentence.push_back(hi);
         SUM_LONG: begin
            sentence.push_back(hi);
            sentence.push_back(lo);
            sentence.push_back(hex_char(4'($urandom_range(0, 15))));
         end
         SUM_STAR: begin
            sentence.push_back(hi);
            sentence.push_back(CH_STAR);
         end
         default: begin
            sentence.push_back(hi);
            sentence.push_back(lo);
         end
      endcase
   endtask

   task automatic directed_sentences();
      begin_rmc(23, 59, 59, CH_STATUS_OK); close_sum(SUM_GOOD); send_sentence();
      begin_rmc(0, 0, 0, CH_STATUS_OK);    close_sum(SUM_GOOD); send_sentence();
      begin_rmc(12, 34, 56, CH_STATUS_VOID); close_sum(SUM_GOOD); send_sentence();
      begin_rmc(12, 0, 0, CH_STATUS_OK);
      sentence[3] ^= 8'h01;
      close_sum(SUM_GOOD); send_sentence();
      begin_rmc(1, 2, 3, CH_STATUS_OK);    close_sum(SUM_BAD);   send_sentence();
      begin_rmc(10, 11, 12, CH_STATUS_OK); add_field(3); close_sum(SUM_LOWER); send_sentence();
      begin_rmc(4, 5, 6, CH_STATUS_OK);    close_sum(SUM_NONE);  send_sentence();
      begin_rmc(4, 5, 6, CH_STATUS_OK);    close_sum(SUM_STAR);  send_sentence();
      begin_rmc(4, 5, 6, CH_STATUS_OK);    close_sum(SUM_LONG);  send_sentence();
      begin_rmc(4, 5, 6, CH_STATUS_OK);    close_sum(SUM_SHORT); send_sentence();
      // time digits just outside '0'..'9'
      begin_rmc(12, 30, 0, CH_STATUS_OK);
      sentence[9] = CH_ZERO - 8'd1;
      close_sum(SUM_GOOD); send_sentence();
      begin_rmc(12, 30, 0, CH_STATUS_OK);
      sentence[12] = CH_NINE + 8'd1;
      close_sum(SUM_GOOD); send_sentence();
      // too short: lone dollar, truncated time, empty time field
      sentence.delete();
      sentence.push_back(CH_DOLLAR);
      send_sentence();
      begin_rmc(12, 0, 0, CH_STATUS_OK);
      sentence = sentence[0:8];
      send_sentence();
      sentence = sentence[0:6];
      sentence.push_back(CH_COMMA);
      sentence.push_back(CH_STATUS_OK);
      close_sum(SUM_GOOD); send_sentence();
      begin_rmc(99, 99, 99, CH_STATUS_OK); close_sum(SUM_GOOD); send_sentence();
      begin_rmc(19, 45, 30, CH_STATUS_OK);
      sentence.push_back(CH_COMMA);
      sentence.push_back(8'h00);
      sentence.push_back(8'hFF);
      close_sum(SUM_GOOD); send_sentence();
      // position counter saturates before the checksum
      begin_rmc(5, 6, 7, CH_STATUS_OK);
      repeat (6) add_field(40);
      close_sum(SUM_GOOD); send_sentence();
      begin_rmc(8, 9, 10, CH_STATUS_OK);
      sentence[0] = CH_STAR;
      close_sum(SUM_GOOD); send_sentence();
   endtask

   task automatic random_sentence();
      int           pick;
      int           hh;
      int           mm;
      int           ss;
      int           len;
      octet_type    status;
      sum_kind_type kind;
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
         hh = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 23);
         mm = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59);
         ss = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59);
         status = ($urandom_range(0, 9) == 0) ? CH_STATUS_VOID : CH_STATUS_OK;
         begin_rmc(hh, mm, ss, status);
         repeat ($urandom_range(0, 3)) add_field($urandom_range(0, 8));
         kind = SUM_GOOD;
         if (pick >= 60) begin
            if ($urandom_range(0, 1) == 0)
               sentence[$urandom_range(0, sentence.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
            else
               kind = sum_kind_type'($urandom_range(SUM_BAD, SUM_NONE));
         end
         close_sum(kind);
      end else begin
         // noise, sometimes opening with a dollar
         sentence.delete();
         len = (pick < 90) ? $urandom_range(1, 20) : $urandom_range(1, 3);
         repeat (len) sentence.push_back(octet_type'($urandom_range(0, 255)));
         if ($urandom_range(0, 1) == 0) sentence[0] = CH_DOLLAR;
      end
      send_sentence();
   endtask

   initial begin
      logic [OFFSET_W-1:0] offsets [NUM_PHASES];
      int                  phase_bytes;
      int                  phase_verdicts;
      offsets = '{5'd0, 5'd23, 5'd31, 5'd24, 5'd8, 5'd0};
      offsets[NUM_PHASES-1] = OFFSET_W'($urandom_range(1, 22));
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed_sentences();

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_offset(offsets[p]);
         tx_gaps   = (p != 1);
         rx_stalls = (p != 1 && p != 4);
         phase_bytes    = 0;
         phase_verdicts = 0;
         while (phase_bytes < PHASE_BYTES || phase_verdicts < PHASE_VERDICTS) begin
            random_sentence();
            phase_bytes += sentence.size();
            phase_verdicts++;
            if ($urandom_range(0, 19) == 0) drain(1'b0);
         end
      end

      drain(1'b1);
      if (sb.mismatches == 0 && sb.expected_q.size() == 0)
         $display("[nmea_rmc_time_extractor] OK");
      else
         $display("[nmea_rmc_time_extractor] ERROR");
      $finish;
   end

endmodule
